### rtl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types and constants for the LRU key/value cache.
// ----------------------------------------------------------------------------
package lkv_pkg;

   // number of entry slots
   localparam int DEPTH = 16;
   // slot index width, at least one bit
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   // occupancy count width, holds DEPTH itself
   localparam int CNT_W = $clog2(DEPTH + 1);
   // capacity register width
   localparam int CAP_W = 5;
   // common width for capacity against occupancy compares
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   // capacity after reset
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
   // key and value width
   localparam int DATA_W = 32;

   // request codes
   localparam logic REQ_GET = 1'b0;
   localparam logic REQ_PUT = 1'b1;

   // read value on a get miss
   localparam logic signed [DATA_W-1:0] MISS_VALUE = -32'sd1;

   // one request word
   typedef struct packed {
      logic                     req_type;
      logic signed [DATA_W-1:0] key;
      logic signed [DATA_W-1:0] value;
   } req_item_type;

   // one response word
   typedef struct packed {
      logic                     found;
      logic signed [DATA_W-1:0] read_value;
   } rsp_item_type;

   // store status seen by the top level
   typedef struct packed {
      logic [CNT_W-1:0] occupancy;
   } lkv_status_type;

endpackage

### rtl/lkv_store.sv
// ----------------------------------------------------------------------------
// lkv_store
// Entry registers in recency order, parallel key match, one-step shift to the
// front and the registered response.
// ----------------------------------------------------------------------------
module lkv_store (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  lkv_pkg::req_item_type         in_item,
   input  logic [lkv_pkg::CMP_W-1:0]     eff_capacity,
   output logic                          rsp_valid,
   output lkv_pkg::rsp_item_type         rsp_data,
   output lkv_pkg::lkv_status_type       status
);

   // entry storage, slot 0 is most recent
   logic [lkv_pkg::DATA_W-1:0] keys_ff   [lkv_pkg::DEPTH];
   logic [lkv_pkg::DATA_W-1:0] keys_in   [lkv_pkg::DEPTH];
   logic [lkv_pkg::DATA_W-1:0] values_ff [lkv_pkg::DEPTH];
   logic [lkv_pkg::DATA_W-1:0] values_in [lkv_pkg::DEPTH];
   logic [lkv_pkg::CNT_W-1:0]  occ_ff;
   logic [lkv_pkg::CNT_W-1:0]  occ_in;

   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   lkv_pkg::rsp_item_type      rsp_data_ff;
   lkv_pkg::rsp_item_type      rsp_data_in;

   logic [lkv_pkg::DEPTH-1:0]  match;
   logic                       hit;
   logic [lkv_pkg::IDX_W-1:0]  hit_at;
   logic                       is_put;
   logic                       full;
   logic                       do_shift;
   logic [lkv_pkg::IDX_W-1:0]  last;
   logic [lkv_pkg::DATA_W-1:0] hit_value;
   logic [lkv_pkg::DATA_W-1:0] front_value;

   // key compare against every valid slot
   always_comb begin
      for (int i = 0; i < lkv_pkg::DEPTH; i++) begin
         match[i] = (lkv_pkg::CNT_W'(i) < occ_ff) && (keys_ff[i] == in_item.key);
      end
   end

   // lowest matching slot
   always_comb begin
      hit    = 1'b0;
      hit_at = '0;
      for (int i = lkv_pkg::DEPTH - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit    = 1'b1;
            hit_at = lkv_pkg::IDX_W'(i);
         end
      end
   end

   assign hit_value = values_ff[hit_at];
   assign is_put    = (in_item.req_type == lkv_pkg::REQ_PUT);
   assign full      = (lkv_pkg::CMP_W'(occ_ff) >= eff_capacity);

   // shift extent and front entry
   always_comb begin
      do_shift    = in_valid && (is_put || hit);
      front_value = is_put ? in_item.value : hit_value;
      occ_in      = occ_ff;
      if (hit) begin
         last = hit_at;
      end else if (full) begin
         last = lkv_pkg::IDX_W'(occ_ff - lkv_pkg::CNT_W'(1));
      end else begin
         last = lkv_pkg::IDX_W'(occ_ff);
         if (do_shift) begin
            occ_in = occ_ff + lkv_pkg::CNT_W'(1);
         end
      end
   end

   // move slots 0 .. last-1 down one, new entry into slot 0
   always_comb begin
      for (int i = 0; i < lkv_pkg::DEPTH; i++) begin
         keys_in[i]   = keys_ff[i];
         values_in[i] = values_ff[i];
         if (do_shift) begin
            if (i == 0) begin
               keys_in[i]   = in_item.key;
               values_in[i] = front_value;
            end else if (lkv_pkg::IDX_W'(i) <= last) begin
               keys_in[i]   = keys_ff[i-1];
               values_in[i] = values_ff[i-1];
            end
         end
      end
   end

   // response word
   always_comb begin
      rsp_valid_in         = in_valid;
      rsp_data_in.found    = hit;
      if (is_put) begin
         rsp_data_in.read_value = '0;
      end else if (hit) begin
         rsp_data_in.read_value = hit_value;
      end else begin
         rsp_data_in.read_value = lkv_pkg::MISS_VALUE;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      keys_ff     <= keys_in;
      values_ff   <= values_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_data_ff;
   assign status.occupancy = occ_ff;

endmodule

### rtl/lru_key_value_cache_core.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_core
// Fully associative key/value cache with least-recently-used replacement.
//
//   channel   handshake            word
//   request   start / busy         req_data (req_type, key, value)
//   response  rsp_valid strobe     rsp_data (found, read_value)
//   config    csr_valid/csr_ready  csr_wdata (capacity)
//
// One request per cycle; the response strobe follows acceptance through the
// request input register and the store's response register. The key match and
// recency shift are combinational. busy stays low and csr_ready stays high.
// Synchronous reset empties the cache (occupancy to zero) and sets capacity to 16.
// The response cannot be stalled; each strobe lasts one cycle.
// ----------------------------------------------------------------------------
module lru_key_value_cache_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  lkv_pkg::req_item_type         req_data,
   output logic                          rsp_valid,
   output lkv_pkg::rsp_item_type         rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lkv_pkg::CAP_W-1:0]     csr_wdata
);

   logic                         in_valid_ff;
   logic                         in_valid_in;
   lkv_pkg::req_item_type        in_item_ff;
   logic [lkv_pkg::CAP_W-1:0]    cap_ff;
   logic [lkv_pkg::CAP_W-1:0]    cap_in;
   logic [lkv_pkg::CMP_W-1:0]    eff_capacity;
   lkv_pkg::lkv_status_type      status;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // capacity register
   assign cap_in = (csr_valid && csr_ready) ? csr_wdata : cap_ff;

   // clamp capacity to 1 .. DEPTH
   always_comb begin
      if (cap_ff == '0) begin
         eff_capacity = lkv_pkg::CMP_W'(1);
      end else if (lkv_pkg::CMP_W'(cap_ff) > lkv_pkg::CMP_W'(lkv_pkg::DEPTH)) begin
         eff_capacity = lkv_pkg::CMP_W'(lkv_pkg::DEPTH);
      end else begin
         eff_capacity = lkv_pkg::CMP_W'(cap_ff);
      end
   end

   // request input register
   assign in_valid_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         cap_ff      <= lkv_pkg::CAP_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         cap_ff      <= cap_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= req_data;
   end

   lkv_store u_store (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (in_valid_ff),
      .in_item      (in_item_ff),
      .eff_capacity (eff_capacity),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data),
      .status       (status)
   );

`ifndef SYNTHESIS
   // occupancy never passes the slot count
   assert property (@(posedge clock) disable iff (reset)
      status.occupancy <= lkv_pkg::CNT_W'(lkv_pkg::DEPTH))
      else $error("occupancy above depth");

   // every accepted request gives a response through the input and response registers
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("response missing after request");

   // occupancy grows by at most one per cycle
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |->
         (status.occupancy <= $past(status.occupancy) + lkv_pkg::CNT_W'(1)))
      else $error("occupancy jumped");
`endif

endmodule
